// ----- sv/clel_pkg.sv -----
// Shared types, character codes and category indexes for the lexer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package clel_pkg;

  // line limit and derived widths
  localparam int unsigned MAX_LINE = 1024;
  localparam int unsigned COL_W    = $clog2(MAX_LINE + 1);

  // fixed field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned LINE_W  = 16;
  localparam int unsigned CAT_W   = 3;
  localparam int unsigned START_W = 10;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned NUM_CAT = 9;
  localparam int unsigned SOLE_W  = 4;

  // candidate indexes
  localparam int unsigned CAT_SYMBOL  = 0;
  localparam int unsigned CAT_INTEGER = 1;
  localparam int unsigned CAT_FLOAT   = 2;
  localparam int unsigned CAT_STRING  = 3;
  localparam int unsigned CAT_ARITH   = 4;
  localparam int unsigned CAT_SCOPE   = 5;
  localparam int unsigned CAT_SEP     = 6;
  localparam int unsigned CAT_SPACING = 7;
  localparam int unsigned CAT_TERM    = 8;

  localparam logic [SOLE_W-1:0] SOLE_SPACING = SOLE_W'(CAT_SPACING);
  localparam logic [SOLE_W-1:0] SOLE_TERM    = SOLE_W'(CAT_TERM);
  localparam logic [SOLE_W-1:0] SOLE_NONE    = 4'hF;
  localparam logic [CAT_W-1:0]  OUT_TERM     = 3'd7;
  localparam logic [CAT_W-1:0]  OUT_ERR_CAT  = 3'd0;

  // character codes
  localparam logic [CHAR_W-1:0] CH_POINT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_QUOTE   = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SEMI    = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_NL      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_EQUAL   = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_LBRACE  = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE  = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_LPAREN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LBRACK  = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACK  = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

  // per-token scan flags
  typedef struct packed {
    logic [NUM_CAT-1:0] cand;
    logic               point_seen;
    logic               float_ok;
    logic               str_closed;
  } scan_st_t;

  localparam scan_st_t SCAN_CLEAR = '{cand: '1, point_seen: 1'b0,
                                      float_ok: 1'b1, str_closed: 1'b0};

  // outcome of checking one character
  typedef struct packed {
    scan_st_t          st;
    logic              any;
    logic              sole;
    logic [SOLE_W-1:0] idx;
  } eval_res_t;

  // one input item
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              line_start;
    logic [LINE_W-1:0] line_number;
  } lex_item_t;

  // one result item
  typedef struct packed {
    logic [CAT_W-1:0]   category;
    logic [START_W-1:0] start_position;
    logic [LEN_W-1:0]   token_length;
    logic [LINE_W-1:0]  token_line;
    logic               error;
  } lex_res_t;

endpackage

`default_nettype wire

// ----- sv/clel_eval.sv -----
// Candidate check of one character at one token position.
// Depends on clel_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clel_eval import clel_pkg::*; (
  input  logic              pos0_i,
  input  logic              pos1_i,
  input  logic [CHAR_W-1:0] char_i,
  input  scan_st_t          st_i,
  output eval_res_t         res_o
);

  scan_st_t           base;
  logic [NUM_CAT-1:0] acc;
  logic [NUM_CAT-1:0] cand_n;
  logic               is_dig;
  logic               is_alpha;
  logic               ps_n;
  logic               fok_n;
  logic               sc_n;
  logic [SOLE_W-1:0]  idx;

  // character classes and accept mask
  always_comb begin
    base     = pos0_i ? SCAN_CLEAR : st_i;
    is_dig   = char_i inside {[8'h30:8'h39]};
    is_alpha = char_i inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    acc      = '0;
    ps_n     = base.point_seen;
    fok_n    = base.float_ok;
    sc_n     = base.str_closed;

    acc[CAT_SYMBOL]  = pos0_i ? is_alpha : (is_alpha | is_dig);
    acc[CAT_INTEGER] = is_dig;

    // float form: digits and exactly one point
    if (!is_dig) begin
      if (char_i == CH_POINT) begin
        if (base.point_seen) fok_n = 1'b0;
        else ps_n = 1'b1;
      end else begin
        fok_n = 1'b0;
      end
    end

    // string: opening quote, then anything up to and including the close
    if (!base.str_closed) begin
      if (pos0_i) begin
        acc[CAT_STRING] = (char_i == CH_QUOTE);
      end else begin
        acc[CAT_STRING] = 1'b1;
        if (char_i == CH_QUOTE) sc_n = 1'b1;
      end
    end

    acc[CAT_ARITH] = (pos0_i && char_i inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                              CH_PERCENT}) ||
                     (pos1_i && char_i inside {CH_EQUAL, CH_PLUS, CH_MINUS, CH_STAR});
    acc[CAT_SCOPE] = pos0_i && char_i inside {CH_LBRACE, CH_RBRACE, CH_LPAREN,
                                              CH_RPAREN, CH_LBRACK, CH_RBRACK};
    acc[CAT_SEP]     = pos0_i && (char_i == CH_COMMA);
    acc[CAT_SPACING] = (char_i == CH_SPACE);
    acc[CAT_TERM]    = (char_i == CH_NL) || (char_i == CH_SEMI);

    cand_n = base.cand & acc;
    cand_n[CAT_FLOAT] = fok_n & ps_n;
  end

  // index of the surviving candidate
  always_comb begin
    idx = '0;
    for (int k = 0; k < NUM_CAT; k++) begin
      if (cand_n[k]) idx = SOLE_W'(k);
    end
  end

  assign res_o.st.cand       = cand_n;
  assign res_o.st.point_seen = ps_n;
  assign res_o.st.float_ok   = fok_n;
  assign res_o.st.str_closed = sc_n;
  assign res_o.any           = |cand_n;
  assign res_o.sole          = $onehot(cand_n);
  assign res_o.idx           = idx;

endmodule

`default_nettype wire

// ----- sv/clel_core.sv -----
// Lexer state and token decision: continue, emit and restart, or error.
// Depends on clel_pkg and clel_eval.
`timescale 1ns / 1ps
`default_nettype none

module clel_core import clel_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      go_i,
  input  lex_item_t item_i,
  output logic      res_vld_o,
  output lex_res_t  res_o
);

  scan_st_t          st_q, st_d, st_eff;
  logic [COL_W-1:0]  col_q, col_d, col_eff;
  logic [COL_W-1:0]  tb_q, tb_d, tb_eff;
  logic [SOLE_W-1:0] sole_q, sole_d, sole_eff;
  logic              halt_q, halt_d, halt_eff;
  logic [COL_W-1:0]  pos;
  eval_res_t         ev_cur, ev_new;
  logic              emit;

  // a line start clears everything before the character is looked at
  always_comb begin
    st_eff   = item_i.line_start ? SCAN_CLEAR : st_q;
    col_eff  = item_i.line_start ? '0 : col_q;
    tb_eff   = item_i.line_start ? '0 : tb_q;
    sole_eff = item_i.line_start ? SOLE_NONE : sole_q;
    halt_eff = item_i.line_start ? 1'b0 : halt_q;
    pos      = col_eff - tb_eff;
  end

  // check at the current position and, in parallel, as a fresh token
  clel_eval u_eval_cur (
    .pos0_i (pos == '0),
    .pos1_i (pos == COL_W'(1)),
    .char_i (item_i.character),
    .st_i   (st_eff),
    .res_o  (ev_cur)
  );

  clel_eval u_eval_new (
    .pos0_i (1'b1),
    .pos1_i (1'b0),
    .char_i (item_i.character),
    .st_i   (st_eff),
    .res_o  (ev_new)
  );

  // decision and next state
  always_comb begin
    st_d      = st_eff;
    col_d     = col_eff;
    tb_d      = tb_eff;
    sole_d    = sole_eff;
    halt_d    = halt_eff;
    res_vld_o = 1'b0;
    emit      = (sole_eff <= SOLE_TERM) && (sole_eff != SOLE_SPACING);

    res_o.category       = OUT_ERR_CAT;
    res_o.start_position = START_W'(col_eff);
    res_o.token_length   = '0;
    res_o.token_line     = item_i.line_number;
    res_o.error          = 1'b1;

    if (!halt_eff) begin
      if (col_eff >= COL_W'(MAX_LINE)) begin
        // overlong line
        halt_d    = 1'b1;
        res_vld_o = 1'b1;
      end else if (ev_cur.any) begin
        st_d  = ev_cur.st;
        col_d = col_eff + COL_W'(1);
        if (ev_cur.sole) sole_d = ev_cur.idx;
      end else begin
        // token ends here, restart on the same character
        st_d = ev_new.st;
        tb_d = col_eff;
        if (!ev_new.any) begin
          halt_d    = 1'b1;
          sole_d    = SOLE_NONE;
          res_vld_o = 1'b1;
        end else begin
          col_d  = col_eff + COL_W'(1);
          sole_d = ev_new.sole ? ev_new.idx : SOLE_NONE;
          if (emit) begin
            res_vld_o            = 1'b1;
            res_o.category       = (sole_eff == SOLE_TERM) ? OUT_TERM
                                                           : CAT_W'(sole_eff);
            res_o.start_position = START_W'(tb_eff);
            res_o.token_length   = LEN_W'(pos);
            res_o.error          = 1'b0;
          end
        end
      end
    end
  end

  // state registers, updated once per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= SCAN_CLEAR;
      col_q  <= '0;
      tb_q   <= '0;
      sole_q <= SOLE_NONE;
      halt_q <= 1'b0;
    end else if (go_i) begin
      st_q   <= st_d;
      col_q  <= col_d;
      tb_q   <= tb_d;
      sole_q <= sole_d;
      halt_q <= halt_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/candidate_elimination_lexer_top.sv -----
// Top level of the candidate-elimination lexer: input register, core, result register.
// Depends on clel_pkg and clel_core.
//
// Usage: one source character per input item on a valid/ready channel, with
// line_start_i marking the first character of each line and line_number_i
// carried into results. Each item yields zero or one result item on the
// output valid/ready channel: a finished token (category, start column,
// length, line) or an error (error_o high, length 0) after which the lexer
// ignores characters until the next line start.
// An accepted item is held in the input register and evaluated from there;
// its result, if any, is captured in the result register when the item advances.
// Throughput: one item per cycle while the receiver does not stall; the
// per-character state update is a single pass through two parallel
// candidate checks between the input register and the result register.
// Reset clears the lexer to the start of a line with no token pending and
// empties both registers. When the receiver stalls, the result register
// holds; the input register still takes one more item, and further items
// wait until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module candidate_elimination_lexer_top import clel_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CHAR_W-1:0]   character_i,
  input  logic                line_start_i,
  input  logic [LINE_W-1:0]   line_number_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CAT_W-1:0]    category_o,
  output logic [START_W-1:0]  start_position_o,
  output logic [LEN_W-1:0]    token_length_o,
  output logic [LINE_W-1:0]   token_line_o,
  output logic                error_o
);

  logic      in_vld_q;
  lex_item_t in_item_q;
  logic      out_vld_q;
  lex_res_t  out_res_q;
  logic      advance;
  logic      res_vld;
  lex_res_t  res;

  // an item moves on when the result register can take its outcome
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= '{character: character_i, line_start: line_start_i,
                     line_number: line_number_i};
    end
  end

  clel_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (advance),
    .item_i    (in_item_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && res_vld) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_vld) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign category_o       = out_res_q.category;
  assign start_position_o = out_res_q.start_position;
  assign token_length_o   = out_res_q.token_length;
  assign token_line_o     = out_res_q.token_line;
  assign error_o          = out_res_q.error;

endmodule

`default_nettype wire

// ----- sv/clel_checker.sv -----
// Port-level checks of the lexer result channel, bound to the top level.
// Depends on clel_pkg and candidate_elimination_lexer_top.
`timescale 1ns / 1ps
`default_nettype none

module clel_checker import clel_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [START_W-1:0] start_position_o,
  input logic [LEN_W-1:0]   token_length_o,
  input logic               error_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // errors carry no length
  a_err_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> token_length_o == '0)
    else $error("error result with nonzero length");

  // tokens are never empty
  a_tok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !error_o |-> token_length_o != '0)
    else $error("empty token emitted");

  // a token ends inside the line
  a_tok_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !error_o |->
      ({{(LEN_W + 1 - START_W){1'b0}}, start_position_o} + {1'b0, token_length_o})
        <= (LEN_W + 1)'(MAX_LINE))
    else $error("token runs past the line limit");

endmodule

bind candidate_elimination_lexer_top clel_checker u_clel_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .start_position_o (start_position_o),
  .token_length_o   (token_length_o),
  .error_o          (error_o)
);

`default_nettype wire
